FILE: hdl/binary_min_heap_priority_queue_defines.svh
// Assertion macros for the binary min-heap priority queue checker.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BMHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bmhpq_pkg.sv
// Shared constants, types and state encoding for the min-heap priority queue.
// No dependencies.
`default_nettype none

package bmhpq_pkg;

    localparam int CAPACITY = 512;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;   // holds 2*pos+2 for any pos

    localparam int KEY_W    = 32;
    localparam int ST_W     = 2;
    localparam int OCC_W    = 10;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIFT_UP,
        S_RM_LOAD,
        S_SIFT_DN,
        S_WR_KEY,
        S_DONE
    } t_state;

    // removed value sits in the low bits, occupancy on top
    typedef struct packed {
        logic [OCC_W-1:0]        occupancy;
        t_status                 status;
        logic signed [KEY_W-1:0] removed;
    } t_result;

    typedef struct packed {
        logic ready;   // core takes a new item
        logic done;    // result held, waiting for the output register
    } t_core_stat;

    localparam int RESULT_W    = KEY_W + ST_W + OCC_W;
    localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

endpackage

`default_nettype wire

FILE: hdl/bmhpq_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bmhpq_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [W-1:0]             o_rdata_a,
    output logic      [W-1:0]             o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: hdl/bmhpq_core.sv
// Heap sequencer: entry count, sift-up and sift-down over the heap RAM.
// Depends on bmhpq_pkg and bmhpq_ram.
`default_nettype none

module bmhpq_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_kind,
    input  wire logic signed [bmhpq_pkg::KEY_W-1:0]  i_value,
    input  wire logic                                i_out_free,
    output bmhpq_pkg::t_core_stat                    o_stat,
    output bmhpq_pkg::t_result                       o_result
);
    import bmhpq_pkg::*;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ADDR_W-1:0]       r_pos, n_pos;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_removed, n_removed;
    t_status                 r_status, n_status;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [KEY_W-1:0]        ram_wdata, ram_rdata_a, ram_rdata_b;

    logic [IDX_W-1:0]        cnt_ext, lc, rc, pick, pick_lc;
    logic signed [KEY_W-1:0] lc_key, rc_key, pick_key, par_key;
    logic [ADDR_W-1:0]       up;

    function automatic logic [IDX_W-1:0] left_of(input logic [ADDR_W-1:0] a);
        return {1'b0, a, 1'b1};
    endfunction

    bmhpq_ram #(
        .W     (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // sift-down child selection; the right child wins a tie
    always_comb begin
        cnt_ext = IDX_W'(r_count);
        lc      = left_of(r_pos);
        rc      = lc + 1'b1;
        lc_key  = $signed(ram_rdata_a);
        rc_key  = $signed(ram_rdata_b);
        if (rc >= cnt_ext || lc_key < rc_key) begin
            pick     = lc;
            pick_key = lc_key;
        end else begin
            pick     = rc;
            pick_key = rc_key;
        end
        pick_lc = left_of(pick[ADDR_W-1:0]);
        par_key = $signed(ram_rdata_a);
        up      = (r_pos - 1'b1) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_removed   = r_removed;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_key;
        ram_raddr_a = '0;
        ram_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    if (i_kind == KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_key   = i_value;
                            if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = i_value;
                                n_state   = S_DONE;
                            end else begin
                                // hole at the new tail, fetch its parent
                                n_pos       = r_count[ADDR_W-1:0];
                                ram_raddr_a = ADDR_W'((r_count - 1'b1) >> 1);
                                n_state     = S_SIFT_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // fetch root and tail together
                            n_count     = r_count - 1'b1;
                            ram_raddr_a = '0;
                            ram_raddr_b = ADDR_W'(r_count - 1'b1);
                            n_state     = S_RM_LOAD;
                        end
                    end
                end
            end

            S_SIFT_UP: begin
                if (par_key < r_key) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // parent moves down into the hole
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata_a;
                    n_pos     = up;
                    if (up == '0) begin
                        n_state = S_WR_KEY;
                    end else begin
                        ram_raddr_a = (up - 1'b1) >> 1;
                    end
                end
            end

            S_RM_LOAD: begin
                n_removed = $signed(ram_rdata_a);
                n_key     = $signed(ram_rdata_b);
                n_pos     = '0;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr_a = ADDR_W'(left_of('0));
                    ram_raddr_b = ADDR_W'(left_of('0) + 1'b1);
                    n_state     = S_SIFT_DN;
                end
            end

            S_SIFT_DN: begin
                ram_we = 1'b1;
                if (lc >= cnt_ext || !(pick_key < r_key)) begin
                    n_state = S_DONE;
                end else begin
                    // smaller child moves up into the hole
                    ram_wdata   = pick_key;
                    n_pos       = pick[ADDR_W-1:0];
                    ram_raddr_a = pick_lc[ADDR_W-1:0];
                    ram_raddr_b = ADDR_W'(pick_lc + 1'b1);
                end
            end

            S_WR_KEY: begin
                ram_we  = 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stat.ready       = (r_state == S_IDLE);
    assign o_stat.done        = (r_state == S_DONE);
    assign o_result.occupancy = OCC_W'(r_count);
    assign o_result.status    = r_status;
    assign o_result.removed   = r_removed;

endmodule

`default_nettype wire

FILE: hdl/binary_min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: stream ports and output register.
// Depends on bmhpq_pkg and bmhpq_core.
//
// Usage:
//   Slave channel s_axis: one item per handshake. tuser carries the kind
//   (0 insert, 1 remove minimum), tdata carries the signed key to insert.
//   Master channel m_axis: exactly one result item for every input item,
//   in order: removed minimum, status (0 ok, 1 full, 2 empty) and the
//   entry count after the item.
//   Items are worked one at a time. The heap lives in a dual-read RAM with
//   registered read data; a sift moves one heap level per step.
//   With the output register free, the time from an accept until tready
//   is back grows with the levels an insert climbs or a remove descends;
//   rejected items (full or empty) go straight to the result.
//   The result reaches m_axis through the output register once the core
//   is done and the register is free.
//   A result waiting in the output register does not block the next item;
//   only a second result finding the register still full waits.
//   Reset clears the entry count, the sequencer state and the output
//   valid; the RAM is not cleared.
`default_nettype none

module binary_min_heap_priority_queue (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [bmhpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] value
    input  wire logic                                 s_axis_tuser,  // [0] kind
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [31:0] removed_value, [33:32] status, [43:34] occupancy, [47:44] zero
    output logic      [bmhpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bmhpq_pkg::*;

    t_core_stat core_stat;
    t_result    core_result;
    logic       start;
    logic       out_free;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    assign s_axis_tready = core_stat.ready;
    assign start         = s_axis_tvalid & core_stat.ready;

    // output register can take a result when empty or being drained now
    assign out_free = !r_m_valid || m_axis_tready;

    bmhpq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (s_axis_tuser),
        .i_value    ($signed(s_axis_tdata[KEY_W-1:0])),
        .i_out_free (out_free),
        .o_stat     (core_stat),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (core_stat.done && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.done && out_free) begin
            r_m_data <= {{OUT_PAD_W{1'b0}}, core_result};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

FILE: hdl/bmhpq_checker.sv
// Port-level checker for the min-heap priority queue, bound to the top level.
// Depends on bmhpq_pkg and binary_min_heap_priority_queue_defines.svh.
`default_nettype none

`include "binary_min_heap_priority_queue_defines.svh"

module bmhpq_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [bmhpq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bmhpq_pkg::*;

    t_result res;
    assign res = t_result'(m_axis_tdata[RESULT_W-1:0]);

    // stalled result holds
    `BMHPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // one item in flight: ready drops right after an accept
    `BMHPQ_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

    // a full reject reports a full heap
    `BMHPQ_ASSERT_NOW(a_full_occ, m_axis_tvalid && res.status == ST_FULL, res.occupancy == OCC_W'(CAPACITY), "full status with wrong occupancy")

    // an empty reject reports nothing held and nothing removed
    `BMHPQ_ASSERT_NOW(a_empty_zero, m_axis_tvalid && res.status == ST_EMPTY, res.occupancy == '0 && res.removed == '0, "empty status with data")

endmodule

bind binary_min_heap_priority_queue bmhpq_checker u_bmhpq_checker (.*);

`default_nettype wire
